// ----- sv/html_escape_stream_assert.svh -----
// Assertion helpers for the HTML escape stream block.
// Both forms sample on clk and are held off while rst_n is low.
`ifndef HTML_ESCAPE_STREAM_ASSERT_SVH
`define HTML_ESCAPE_STREAM_ASSERT_SVH

// Same-cycle implication.
`define HES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hes_pkg.sv -----
package hes_pkg;

  // Lane count and packed word size (a word must fit 64 bits)
  localparam int LANES      = 8;
  localparam int WORD_BYTES = (LANES < 8) ? LANES : 8;
  localparam int WORD_BITS  = WORD_BYTES * 8;

  // Longest entity is six bytes
  localparam int ENT_BYTES = 6;
  localparam int LEN_W     = $clog2(ENT_BYTES + 1);

  // Expanded bytes of one transaction, and the packer's accumulator
  localparam int EXP_BYTES = WORD_BYTES * ENT_BYTES;
  localparam int EXP_BITS  = EXP_BYTES * 8;
  localparam int OFF_W     = $clog2(EXP_BYTES + 1);
  localparam int ACC_BYTES = WORD_BYTES - 1 + EXP_BYTES;
  localparam int ACC_BITS  = ACC_BYTES * 8;
  localparam int CNT_W     = $clog2(ACC_BYTES + 1);
  localparam int SH_W      = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

  // Port widths
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 4;

  // Expanded transaction handed from the lane stage to the packer
  typedef struct packed {
    logic [EXP_BITS-1:0] bytes;
    logic [OFF_W-1:0]    len;
    logic                last;
  } hes_exp_t;

endpackage

// ----- sv/hes_lane.sv -----
module hes_lane (
  input  logic [7:0]                          lane_byte,
  input  logic                                lane_on,
  output logic [hes_pkg::LEN_W-1:0]           lane_len,
  output logic [hes_pkg::ENT_BYTES*8-1:0]     lane_ent
);
  import hes_pkg::*;

  // Marks
  localparam logic [7:0] MARK_AMP  = 8'h26;
  localparam logic [7:0] MARK_LT   = 8'h3C;
  localparam logic [7:0] MARK_GT   = 8'h3E;
  localparam logic [7:0] MARK_QUOT = 8'h22;
  localparam logic [7:0] MARK_APOS = 8'h27;

  // Entities, first character in the low byte
  localparam logic [ENT_BYTES*8-1:0] ENT_AMP  = 48'h00_3B_70_6D_61_26;
  localparam logic [ENT_BYTES*8-1:0] ENT_LT   = 48'h00_00_3B_74_6C_26;
  localparam logic [ENT_BYTES*8-1:0] ENT_GT   = 48'h00_00_3B_74_67_26;
  localparam logic [ENT_BYTES*8-1:0] ENT_QUOT = 48'h3B_74_6F_75_71_26;
  localparam logic [ENT_BYTES*8-1:0] ENT_APOS = 48'h00_3B_39_33_23_26;

  // Classify one byte; an inactive lane contributes nothing
  always_comb begin
    lane_len = LEN_W'(1);
    lane_ent = {{(ENT_BYTES*8-8){1'b0}}, lane_byte};
    case (lane_byte)
      MARK_AMP: begin
        lane_len = LEN_W'(5);
        lane_ent = ENT_AMP;
      end
      MARK_LT: begin
        lane_len = LEN_W'(4);
        lane_ent = ENT_LT;
      end
      MARK_GT: begin
        lane_len = LEN_W'(4);
        lane_ent = ENT_GT;
      end
      MARK_QUOT: begin
        lane_len = LEN_W'(6);
        lane_ent = ENT_QUOT;
      end
      MARK_APOS: begin
        lane_len = LEN_W'(5);
        lane_ent = ENT_APOS;
      end
      default: begin
        lane_len = LEN_W'(1);
      end
    endcase
    if (!lane_on) begin
      lane_len = '0;
      lane_ent = '0;
    end
  end

endmodule

// ----- sv/hes_expand.sv -----
module hes_expand (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hes_pkg::DATA_W-1:0]  in_bytes,
  input  logic [hes_pkg::COUNT_W-1:0] in_count,
  input  logic                        in_last,
  output logic                        exp_valid,
  input  logic                        exp_take,
  output hes_pkg::hes_exp_t           exp_data
);
  import hes_pkg::*;

  logic [COUNT_W-1:0]     cnt_sat;
  logic [LEN_W-1:0]       len [WORD_BYTES];
  logic [ENT_BYTES*8-1:0] ent [WORD_BYTES];
  logic [OFF_W-1:0]       off [WORD_BYTES+1];
  logic [EXP_BITS-1:0]    merged;
  logic                   accept;

  logic     s1_valid_r, s1_valid_nxt;
  hes_exp_t s1_data_r;

  // Counts above one word saturate
  assign cnt_sat = (in_count > COUNT_W'(WORD_BYTES)) ? COUNT_W'(WORD_BYTES) : in_count;

  // One lane per input byte
  for (genvar i = 0; i < WORD_BYTES; i++) begin : g_lane
    hes_lane u_lane (
      .lane_byte (in_bytes[8*i +: 8]),
      .lane_on   (COUNT_W'(i) < cnt_sat),
      .lane_len  (len[i]),
      .lane_ent  (ent[i])
    );
  end

  // Running offsets of each lane's output
  always_comb begin
    off[0] = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      off[i+1] = off[i] + OFF_W'(len[i]);
    end
  end

  // Merge: place each lane's bytes at its offset
  always_comb begin
    merged = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      merged = merged | (EXP_BITS'(ent[i]) << {off[i], 3'b000});
    end
  end

  // Stage register toward the packer
  assign in_stall  = s1_valid_r && !exp_take;
  assign accept    = in_valid && !in_stall;
  assign exp_valid = s1_valid_r;
  assign exp_data  = s1_data_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (exp_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r.bytes <= merged;
      s1_data_r.len   <= off[WORD_BYTES];
      s1_data_r.last  <= in_last;
    end
  end

endmodule

// ----- sv/hes_pack.sv -----
module hes_pack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        exp_valid,
  output logic                        exp_take,
  input  hes_pkg::hes_exp_t           exp_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hes_pkg::DATA_W-1:0]  out_bytes,
  output logic [hes_pkg::COUNT_W-1:0] out_count,
  output logic                        out_last
);
  import hes_pkg::*;

  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]    acc_cnt_r, acc_cnt_nxt;
  logic                fin_r, fin_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_bytes_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;

  logic                out_free, full, fire_full, fire_fin;
  logic [ACC_BITS-1:0] base_bytes;
  logic [CNT_W-1:0]    base_cnt;
  logic                base_fin;
  logic [SH_W-1:0]     shift;

  // Drain: full words first, then the final word of a value
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = acc_cnt_r >= CNT_W'(WORD_BYTES);
  assign fire_full = out_free && full;
  assign fire_fin  = out_free && !full && fin_r;

  // Accumulator after this cycle's word leaves
  always_comb begin
    base_bytes = acc_r;
    base_cnt   = acc_cnt_r;
    if (fire_full) begin
      base_bytes = acc_r >> WORD_BITS;
      base_cnt   = acc_cnt_r - CNT_W'(WORD_BYTES);
    end else if (fire_fin) begin
      base_bytes = '0;
      base_cnt   = '0;
    end
  end
  assign base_fin = fin_r && !fire_fin;

  // Append a new transaction once less than a word remains and no final word is pending
  assign exp_take = exp_valid && !base_fin && (base_cnt < CNT_W'(WORD_BYTES));
  assign shift    = base_cnt[SH_W-1:0];

  always_comb begin
    acc_nxt     = base_bytes;
    acc_cnt_nxt = base_cnt;
    fin_nxt     = base_fin;
    if (exp_take) begin
      acc_nxt     = base_bytes | (ACC_BITS'(exp_data.bytes) << {shift, 3'b000});
      acc_cnt_nxt = base_cnt + CNT_W'(exp_data.len);
      fin_nxt     = exp_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      acc_cnt_r <= '0;
      fin_r     <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      fin_r     <= fin_nxt;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_full || fire_fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_full || fire_fin) begin
      out_bytes_r <= DATA_W'(acc_r[WORD_BITS-1:0]);
      out_count_r <= fire_full ? COUNT_W'(WORD_BYTES) : COUNT_W'(acc_cnt_r);
      out_last_r  <= fire_fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bytes = out_bytes_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

endmodule

// ----- sv/html_escape_stream.sv -----
// Channel  Handshake            Payload
// in_      in_valid/in_stall    in_bytes[63:0] in_count[3:0] in_last
// out_     out_valid/out_stall  out_bytes[63:0] out_count[3:0] out_last
//
// One input transaction per cycle while out_stall is low, unless it completes several words: a
// transaction holds the packer while its output words leave (full words, plus the final word
// of a last transaction).
// Output passes the lane-stage register, the packer accumulator and the output register.
// Reset (rst_n, synchronous) clears the held remainder; no clearing pass is needed.
// in_stall rises while the lane stage holds a transaction the packer cannot yet take.
module html_escape_stream (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hes_pkg::DATA_W-1:0]  in_bytes,
  input  logic [hes_pkg::COUNT_W-1:0] in_count,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hes_pkg::DATA_W-1:0]  out_bytes,
  output logic [hes_pkg::COUNT_W-1:0] out_count,
  output logic                        out_last
);
  import hes_pkg::*;

  logic     exp_valid;
  logic     exp_take;
  hes_exp_t exp_data;

  // Lanes and merge
  hes_expand u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_bytes  (in_bytes),
    .in_count  (in_count),
    .in_last   (in_last),
    .exp_valid (exp_valid),
    .exp_take  (exp_take),
    .exp_data  (exp_data)
  );

  // Word packer
  hes_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .exp_valid (exp_valid),
    .exp_take  (exp_take),
    .exp_data  (exp_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (out_last)
  );

`include "html_escape_stream_assert.svh"

  `HES_ASSERT_NOW(a_full_unless_last, out_valid && !out_last, out_count == COUNT_W'(WORD_BYTES), "non-final word not full")
  `HES_ASSERT_NOW(a_stall_needs_held, in_stall, exp_valid, "input stalled with empty lane stage")
  `HES_ASSERT_NEXT(a_held_stable, exp_valid && !exp_take, exp_valid && $stable(exp_data), "held transaction changed")

endmodule

// ----- sim/html_escape_checker.sv -----
module html_escape_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [hes_pkg::DATA_W-1:0]  in_bytes,
  input  logic [hes_pkg::COUNT_W-1:0] in_count,
  input  logic                        in_last,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [hes_pkg::DATA_W-1:0]  out_bytes,
  input  logic [hes_pkg::COUNT_W-1:0] out_count,
  input  logic                        out_last,
  output int                          mismatches,
  output int                          words_waiting
);
  import hes_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  bytes;
    logic [COUNT_W-1:0] count;
    logic               last;
  } out_word_t;

  // Escaped words not yet seen on the output, oldest first
  out_word_t escaped_words[$];
  // Escaped text held back until a full word or the end of the value
  logic [7:0] held_text[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++)
      held_text.push_back(s[i]);
  endtask

  // Escape one input transaction and pack whatever words it completes
  task automatic escape_transaction(input logic [DATA_W-1:0] text,
                                    input logic [COUNT_W-1:0] count,
                                    input logic last);
    int        n;
    logic [7:0] c;
    out_word_t w;
    n = (count > WORD_BYTES) ? WORD_BYTES : int'(count);
    for (int i = 0; i < n; i++) begin
      c = text[8*i +: 8];
      case (c)
        "&":     append_text("&amp;");
        "<":     append_text("&lt;");
        ">":     append_text("&gt;");
        "\"":    append_text("&quot;");
        "'":     append_text("&#39;");
        default: held_text.push_back(c);
      endcase
    end
    // full words never carry last
    while (held_text.size() >= WORD_BYTES) begin
      w       = '0;
      w.count = COUNT_W'(WORD_BYTES);
      for (int j = 0; j < WORD_BYTES; j++)
        w.bytes[8*j +: 8] = held_text.pop_front();
      escaped_words.push_back(w);
    end
    // end of value: flush the remainder, possibly empty
    if (last) begin
      w       = '0;
      w.count = COUNT_W'(held_text.size());
      w.last  = 1'b1;
      for (int j = 0; held_text.size() != 0; j++)
        w.bytes[8*j +: 8] = held_text.pop_front();
      escaped_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      escaped_words.delete();
      held_text.delete();
    end else begin
      // output side: compare against the oldest expected word
      if (out_valid && !out_stall) begin
        if (escaped_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word bytes=%h count=%0d last=%b",
                                    out_bytes, out_count, out_last));
        end else begin
          want = escaped_words.pop_front();
          if (out_bytes !== want.bytes)
            report_mismatch($sformatf("out_bytes %h, expected %h", out_bytes, want.bytes));
          if (out_count !== want.count)
            report_mismatch($sformatf("out_count %0d, expected %0d", out_count, want.count));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %b, expected %b", out_last, want.last));
        end
      end
      // input side: predict the words this transaction causes
      if (in_valid && !in_stall)
        escape_transaction(in_bytes, in_count, in_last);
    end
    words_waiting <= escaped_words.size();
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import hes_pkg::*;

  localparam int RANDOM_ITEMS = 260;
  localparam int CALM_FROM    = 220;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 300000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [DATA_W-1:0]  in_bytes  = '0;
  logic [COUNT_W-1:0] in_count  = '0;
  logic               in_last   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DATA_W-1:0]  out_bytes;
  logic [COUNT_W-1:0] out_count;
  logic               out_last;

  int          mismatches;
  int          words_waiting;
  logic        calm        = 1'b0;
  int          stall_left  = 0;
  int unsigned cycle_count = 0;

  always #10 clk = ~clk;

  html_escape_stream i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_bytes  (in_bytes),
    .in_count  (in_count),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bytes (out_bytes),
    .out_count (out_count),
    .out_last  (out_last)
  );

  html_escape_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_bytes      (in_bytes),
    .in_count      (in_count),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bytes     (out_bytes),
    .out_count     (out_count),
    .out_last      (out_last),
    .mismatches    (mismatches),
    .words_waiting (words_waiting)
  );

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cycle limit reached, %0d words still expected", words_waiting);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] pack_text(input string s);
    logic [DATA_W-1:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++)
      w[8*i +: 8] = s[i];
    return w;
  endfunction

  // Text byte biased toward the five marks
  function automatic logic [7:0] random_text_byte();
    case ($urandom_range(0, 11))
      0:       return "&";
      1:       return "<";
      2:       return ">";
      3:       return "\"";
      4:       return "'";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one transaction, with an occasional idle gap ahead of it
  task automatic push_text(input logic [DATA_W-1:0] text, input logic [COUNT_W-1:0] count,
                           input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bytes <= text;
    in_count <= count;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every expected word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
  endtask

  initial begin
    int                 sent;
    int                 value_len;
    logic [DATA_W-1:0]  text;
    logic [COUNT_W-1:0] count;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty value, exact fill, all marks, worst-case expansion
    push_text('0, 4'd0, 1'b1);
    push_text(pack_text("abcdefgh"), 4'd8, 1'b1);
    push_text(pack_text("&<>\"'"), 4'd5, 1'b0);
    push_text(pack_text("xy"), 4'd2, 1'b1);
    push_text(pack_text("1234567"), 4'd7, 1'b0);
    push_text(pack_text("\"\"\"\"\"\"\"\""), 4'd8, 1'b1);
    // oversized counts saturate
    push_text('1, 4'd15, 1'b0);
    push_text({8{8'h3c}}, 4'd9, 1'b1);
    // marks above the count are ignored
    push_text(pack_text("ab&<>\"'&"), 4'd2, 1'b1);
    push_text('0, 4'd8, 1'b0);
    push_text('0, 4'd0, 1'b0);
    push_text(pack_text("&&&&&&&&"), 4'd8, 1'b0);
    push_text(pack_text("''''''''"), 4'd8, 1'b1);
    push_text(64'h8040_2010_0804_0201, 4'd8, 1'b0);
    push_text(64'h7fbf_dfef_f7fb_fdfe, 4'd8, 1'b1);
    wait_drained();

    // Random values of 1 to 6 transactions, the last one flagged
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      value_len = $urandom_range(1, 6);
      for (int k = 0; k < value_len; k++) begin
        if (sent >= CALM_FROM)
          calm <= 1'b1;
        for (int i = 0; i < 8; i++)
          text[8*i +: 8] = random_text_byte();
        if ($urandom_range(0, 9) == 0)
          count = COUNT_W'($urandom_range(9, 15));
        else
          count = COUNT_W'($urandom_range(0, 8));
        push_text(text, count, k == value_len - 1);
        sent++;
      end
      if (sent < CALM_FROM && $urandom_range(0, 14) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
